FILE: hdl/dgrnn_pkg.sv
// ----------------------------------------------------------------------------
// Diagonal RNN step package
// Shared widths, register indexes, payload structs and state types.
// ----------------------------------------------------------------------------
package dgrnn_pkg;

	localparam int LANES = 1024;
	localparam int LANE_W = 10;
	localparam int DATA_W = 16;
	localparam int GATE_W = 18;
	localparam int CFG_IDX_W = 2;
	localparam int SQUARINGS = 6;
	localparam int DIV_STEPS = 61;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELTA_RULE = 2'd0,
		CFG_USE_TANH   = 2'd1,
		CFG_DECAY      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                     kind;
		logic [LANE_W-1:0]        lane;
		logic signed [DATA_W-1:0] k_value;
		logic signed [DATA_W-1:0] v_value;
		logic signed [DATA_W-1:0] init_state;
	} in_item_t;

	typedef struct packed {
		logic [LANE_W-1:0]        lane_out;
		logic signed [DATA_W-1:0] pre_activation;
		logic signed [DATA_W-1:0] new_state;
		logic [GATE_W-1:0]        gated_out;
	} out_item_t;

	typedef struct packed {
		logic               start;
		logic signed [17:0] y;
	} sig_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [30:0] q;
	} sig_rsp_t;

	typedef enum logic [3:0] {
		SG_IDLE,
		SG_Z2,
		SG_Z3,
		SG_Z4,
		SG_D6,
		SG_D24,
		SG_SQ,
		SG_DIV,
		SG_DONE
	} sig_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE1,
		ST_PRE2,
		ST_TANH_GO,
		ST_TANH_WAIT,
		ST_GATE_GO,
		ST_GATE_WAIT,
		ST_FIN
	} step_state_t;

endpackage

FILE: hdl/dgrnn_state_ram.sv
// ----------------------------------------------------------------------------
// Lane state memory
// One signed Q4.12 value per lane, one write and one registered read port.
// ----------------------------------------------------------------------------
module dgrnn_state_ram (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [dgrnn_pkg::LANE_W-1:0]          waddr,
	input  logic signed [dgrnn_pkg::DATA_W-1:0]   wdata,
	input  logic                                  re,
	input  logic [dgrnn_pkg::LANE_W-1:0]          raddr,
	output logic signed [dgrnn_pkg::DATA_W-1:0]   rdata
);

	logic signed [dgrnn_pkg::DATA_W-1:0] mem [dgrnn_pkg::LANES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/dgrnn_sigmoid.sv
// ----------------------------------------------------------------------------
// Iterative sigmoid unit
// Series exp(-|y|) with repeated squaring on one shared multiplier, then a
// bit-serial restoring divide for the rounded reciprocal.
// ----------------------------------------------------------------------------
module dgrnn_sigmoid (
	input  logic                clk,
	input  logic                arst_n,
	input  dgrnn_pkg::sig_req_t req,
	output dgrnn_pkg::sig_rsp_t rsp
);

	localparam logic [31:0] RECIP3 = 32'd22369621;
	localparam int RECIP_SH = 26;

	dgrnn_pkg::sig_state_t state_q, state_d;

	logic [2:0]  sq_cnt_q;
	logic [5:0]  div_cnt_q;
	logic        neg_q;
	logic [28:0] z_q;
	logic [31:0] z2_q, z3_q, z4_q, d6_q;
	logic [31:0] den_q, rem_q;
	logic [60:0] num_q;
	logic [30:0] quot_q;
	logic [63:0] prod_q;

	logic [18:0] a_abs;
	logic [16:0] a_cl;
	logic [28:0] z_in;
	logic [31:0] prod_hi;
	logic [31:0] x_sel, qe, r3, d3;
	logic [32:0] p_wide;
	logic [30:0] p_init, p_sq;
	logic [63:0] sq_round;
	logic [31:0] den_next;
	logic [31:0] trial;
	logic        ge;
	logic [31:0] mul_a, mul_b;

	always_comb begin
		a_abs = req.y[17] ? (19'd0 - {req.y[17], req.y}) : {1'b0, req.y};
		a_cl = (a_abs > 19'd65536) ? 17'd65536 : a_abs[16:0];
		z_in = {a_cl, 12'b0};
		prod_hi = prod_q[61:30];
		x_sel = (state_q == dgrnn_pkg::SG_D6) ? (z3_q >> 1) : (z4_q >> 3);
		qe = 32'(prod_q >> RECIP_SH);
		r3 = x_sel - (qe << 1) - qe;
		d3 = (r3 >= 32'd3) ? qe + 32'd1 : qe;
		p_wide = 33'(dgrnn_pkg::Q30_ONE) + 33'(z2_q >> 1) + 33'(d3)
			- 33'(z_q) - 33'(d6_q);
		p_init = p_wide[30:0];
		sq_round = prod_q + 64'(32'h2000_0000);
		p_sq = sq_round[60:30];
		den_next = 32'(dgrnn_pkg::Q30_ONE) + 32'(p_sq);
		trial = {rem_q[30:0], num_q[60]};
		ge = (trial >= den_q);
	end

	always_comb begin
		case (state_q)
			dgrnn_pkg::SG_IDLE: begin
				mul_a = 32'(z_in);
				mul_b = 32'(z_in);
			end
			dgrnn_pkg::SG_Z2, dgrnn_pkg::SG_Z3: begin
				mul_a = prod_hi;
				mul_b = 32'(z_q);
			end
			dgrnn_pkg::SG_Z4: begin
				mul_a = z3_q >> 1;
				mul_b = RECIP3;
			end
			dgrnn_pkg::SG_D6: begin
				mul_a = z4_q >> 3;
				mul_b = RECIP3;
			end
			dgrnn_pkg::SG_D24: begin
				mul_a = 32'(p_init);
				mul_b = 32'(p_init);
			end
			dgrnn_pkg::SG_SQ: begin
				mul_a = 32'(p_sq);
				mul_b = 32'(p_sq);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dgrnn_pkg::SG_IDLE: if (req.start) state_d = dgrnn_pkg::SG_Z2;
			dgrnn_pkg::SG_Z2:   state_d = dgrnn_pkg::SG_Z3;
			dgrnn_pkg::SG_Z3:   state_d = dgrnn_pkg::SG_Z4;
			dgrnn_pkg::SG_Z4:   state_d = dgrnn_pkg::SG_D6;
			dgrnn_pkg::SG_D6:   state_d = dgrnn_pkg::SG_D24;
			dgrnn_pkg::SG_D24:  state_d = dgrnn_pkg::SG_SQ;
			dgrnn_pkg::SG_SQ: begin
				if (sq_cnt_q == 3'(dgrnn_pkg::SQUARINGS - 1)) state_d = dgrnn_pkg::SG_DIV;
			end
			dgrnn_pkg::SG_DIV: begin
				if (div_cnt_q == 6'(dgrnn_pkg::DIV_STEPS - 1)) state_d = dgrnn_pkg::SG_DONE;
			end
			dgrnn_pkg::SG_DONE: state_d = dgrnn_pkg::SG_IDLE;
			default:            state_d = dgrnn_pkg::SG_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy = (state_q != dgrnn_pkg::SG_IDLE);
		rsp.done = (state_q == dgrnn_pkg::SG_DONE);
		rsp.q = neg_q ? (dgrnn_pkg::Q30_ONE - quot_q) : quot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dgrnn_pkg::SG_IDLE;
			sq_cnt_q <= 3'd0;
			div_cnt_q <= 6'd0;
		end else begin
			state_q <= state_d;
			if (state_q == dgrnn_pkg::SG_D24) begin
				sq_cnt_q <= 3'd0;
			end else if (state_q == dgrnn_pkg::SG_SQ) begin
				sq_cnt_q <= sq_cnt_q + 3'd1;
			end
			if (state_q == dgrnn_pkg::SG_SQ) begin
				div_cnt_q <= 6'd0;
			end else if (state_q == dgrnn_pkg::SG_DIV) begin
				div_cnt_q <= div_cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			dgrnn_pkg::SG_IDLE: begin
				if (req.start) begin
					z_q <= z_in;
					neg_q <= req.y[17];
				end
			end
			dgrnn_pkg::SG_Z2: z2_q <= prod_hi;
			dgrnn_pkg::SG_Z3: z3_q <= prod_hi;
			dgrnn_pkg::SG_Z4: z4_q <= prod_hi;
			dgrnn_pkg::SG_D6: d6_q <= d3;
			dgrnn_pkg::SG_SQ: begin
				den_q <= den_next;
				num_q <= (61'd1 << 60) + 61'(den_next >> 1);
				rem_q <= 32'd0;
				quot_q <= 31'd0;
			end
			dgrnn_pkg::SG_DIV: begin
				rem_q <= ge ? (trial - den_q) : trial;
				num_q <= num_q << 1;
				quot_q <= {quot_q[29:0], ge};
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/diagonal_rnn_forward_step_unit.sv
// ----------------------------------------------------------------------------
// Diagonal RNN forward step unit
// Load transactions fill a lane's state; step transactions update it and
// return the pre-activation, new state and self-gated output.
// Loads are written to the state memory when accepted. A step holds the input
// until its result enters the output register, which waits while the output
// still holds an untaken result. The sigmoid unit is called once without tanh
// and twice with it. One item is in flight at a time.
// Reset restores the registers to delta rule, tanh on and decay 1.0; the
// state memory is not cleared and a lane must be loaded before a step.
// ----------------------------------------------------------------------------
module diagonal_rnn_forward_step_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  dgrnn_pkg::in_item_t                    in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output dgrnn_pkg::out_item_t                   out_data,
	input  logic                                   cfg_we,
	input  logic [dgrnn_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dgrnn_pkg::DATA_W-1:0]           cfg_data
);

	function automatic logic signed [15:0] sat16(input logic signed [48:0] x);
		if (x > 49'sd32767) return 16'sh7FFF;
		if (x < -49'sd32768) return 16'sh8000;
		return x[15:0];
	endfunction

	dgrnn_pkg::step_state_t state_q, state_d;

	logic                     delta_q, tanh_q;
	logic signed [15:0]       decay_q;
	dgrnn_pkg::in_item_t      item_q;
	dgrnn_pkg::out_item_t     out_q;
	logic                     out_valid_q;
	logic signed [15:0]       s_q, pre_q, ns_q;
	logic signed [31:0]       kk_q, vk_q, ds_q;
	logic [30:0]              nn_q;
	logic [61:0]              g_q;

	dgrnn_pkg::sig_req_t      sig_req;
	dgrnn_pkg::sig_rsp_t      sig_rsp;

	logic                     accept, fin_fire;
	logic                     ram_we, ram_re;
	logic [dgrnn_pkg::LANE_W-1:0] ram_waddr;
	logic signed [15:0]       ram_wdata, ram_rdata;

	logic signed [32:0]       one_minus;
	logic signed [48:0]       dsum, ssum, dround, sround;
	logic signed [15:0]       pre_next;
	logic signed [32:0]       t33, tr;
	logic signed [15:0]       ns_tanh;
	logic signed [31:0]       nn_full;
	logic [61:0]              g_round;
	logic [19:0]              gate_raw;
	logic [17:0]              gate_val;

	assign accept = in_valid && in_ready;
	assign fin_fire = (state_q == dgrnn_pkg::ST_FIN) && (!out_valid_q || out_ready);
	assign ram_re = accept && (in_data.kind == dgrnn_pkg::KIND_STEP);
	assign ram_we = (accept && (in_data.kind == dgrnn_pkg::KIND_LOAD)) || fin_fire;
	assign ram_waddr = fin_fire ? item_q.lane : in_data.lane;
	assign ram_wdata = fin_fire ? ns_q : in_data.init_state;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	dgrnn_state_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (in_data.lane),
		.rdata (ram_rdata)
	);

	dgrnn_sigmoid u_sigmoid (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sig_req),
		.rsp    (sig_rsp)
	);

	always_comb begin
		one_minus = 33'sd16777216 - 33'(kk_q);
		dsum = s_q * one_minus + (49'(vk_q) <<< 12);
		ssum = 49'(ds_q) + 49'(vk_q);
		dround = (dsum + 49'sd8388608) >>> 24;
		sround = (ssum + 49'sd2048) >>> 12;
		pre_next = sat16(delta_q ? dround : sround);
		t33 = $signed({1'b0, sig_rsp.q, 1'b0}) - 33'sd1073741824;
		tr = (t33 + 33'sd131072) >>> 18;
		ns_tanh = sat16(49'(tr));
		nn_full = ns_q * ns_q;
		g_round = g_q + 62'(42'h200_0000_0000);
		gate_raw = g_round[61:42];
		gate_val = (gate_raw[19:18] != 2'b00) ? 18'h3FFFF : gate_raw[17:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dgrnn_pkg::ST_IDLE: begin
				if (accept && (in_data.kind == dgrnn_pkg::KIND_STEP)) state_d = dgrnn_pkg::ST_PRE1;
			end
			dgrnn_pkg::ST_PRE1:      state_d = dgrnn_pkg::ST_PRE2;
			dgrnn_pkg::ST_PRE2:      state_d = tanh_q ? dgrnn_pkg::ST_TANH_GO : dgrnn_pkg::ST_GATE_GO;
			dgrnn_pkg::ST_TANH_GO:   state_d = dgrnn_pkg::ST_TANH_WAIT;
			dgrnn_pkg::ST_TANH_WAIT: if (sig_rsp.done) state_d = dgrnn_pkg::ST_GATE_GO;
			dgrnn_pkg::ST_GATE_GO:   state_d = dgrnn_pkg::ST_GATE_WAIT;
			dgrnn_pkg::ST_GATE_WAIT: if (sig_rsp.done) state_d = dgrnn_pkg::ST_FIN;
			dgrnn_pkg::ST_FIN:       if (fin_fire) state_d = dgrnn_pkg::ST_IDLE;
			default:                 state_d = dgrnn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == dgrnn_pkg::ST_IDLE);
		sig_req.start = (state_q == dgrnn_pkg::ST_TANH_GO) || (state_q == dgrnn_pkg::ST_GATE_GO);
		sig_req.y = (state_q == dgrnn_pkg::ST_TANH_GO) ? {pre_q[15], pre_q, 1'b0}
			: {{2{ns_q[15]}}, ns_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dgrnn_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			delta_q <= 1'b1;
			tanh_q <= 1'b1;
			decay_q <= 16'sd4096;
		end else begin
			state_q <= state_d;
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					dgrnn_pkg::CFG_DELTA_RULE: delta_q <= cfg_data[0];
					dgrnn_pkg::CFG_USE_TANH:   tanh_q <= cfg_data[0];
					dgrnn_pkg::CFG_DECAY:      decay_q <= $signed(cfg_data);
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		case (state_q)
			dgrnn_pkg::ST_PRE1: begin
				s_q <= ram_rdata;
				kk_q <= item_q.k_value * item_q.k_value;
				vk_q <= item_q.v_value * item_q.k_value;
				ds_q <= decay_q * ram_rdata;
			end
			dgrnn_pkg::ST_PRE2: begin
				pre_q <= pre_next;
				ns_q <= pre_next;
			end
			dgrnn_pkg::ST_TANH_WAIT: begin
				if (sig_rsp.done) ns_q <= ns_tanh;
			end
			dgrnn_pkg::ST_GATE_GO: begin
				nn_q <= nn_full[30:0];
			end
			dgrnn_pkg::ST_GATE_WAIT: begin
				if (sig_rsp.done) g_q <= 62'(nn_q) * 62'(sig_rsp.q);
			end
			default: begin
			end
		endcase
		if (fin_fire) begin
			out_q.lane_out <= item_q.lane;
			out_q.pre_activation <= pre_q;
			out_q.new_state <= ns_q;
			out_q.gated_out <= gate_val;
		end
	end

	a_sig_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sig_req.start |-> !sig_rsp.busy)
		else $error("sigmoid started while busy");

	a_sig_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sig_rsp.done |-> (state_q == dgrnn_pkg::ST_TANH_WAIT ||
			state_q == dgrnn_pkg::ST_GATE_WAIT))
		else $error("sigmoid result arrived with no waiting step");

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("state memory read and written in the same cycle");

	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		sig_rsp.done |-> (sig_rsp.q <= dgrnn_pkg::Q30_ONE))
		else $error("sigmoid result above one");

endmodule
